[src/pvb_pkg.sv]
// ----------------------------------------------------------------------------
// pvb_pkg: shared types and constants of the point voxel binning histogram
// Grid sizing, counter width, register codes, stage and result structs.
// ----------------------------------------------------------------------------
package pvb_pkg;

  // Grid and counter sizing
  localparam int MAX_DEPTH  = 4;                 // log2 of the largest cells per axis
  localparam int COUNT_BITS = 32;                // width of one cell counter
  localparam int CELL_W     = MAX_DEPTH;         // internal cell coordinate width
  localparam int CIDX_W     = 3 * MAX_DEPTH;     // internal linear index width
  localparam int NUM_CELLS  = 1 << CIDX_W;       // counter memory depth

  // Fixed field widths of the streams
  localparam int DATA_W      = 32;               // position, origin, scale, totals
  localparam int CLASS_W     = 8;
  localparam int COORD_W     = 4;                // cell_x/y/z on the result stream
  localparam int IDX_W       = 12;               // cell_index on the result stream
  localparam int OUT_CNT_W   = 32;               // cell_count on the result stream
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 96;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int DEPTH_W   = 3;                  // grid_depth register width
  localparam logic [DATA_W-1:0]  SCALE_RESET = 32'h0001_0000;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_ORIGIN_Z   = 3'd2,
    CFG_CELL_SCALE = 3'd3,
    CFG_GRID_DEPTH = 3'd4
  } cfg_reg_t;

  // Output FIFO, also sets the number of points in flight
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [DATA_W-1:0]  origin_x;
    logic [DATA_W-1:0]  origin_y;
    logic [DATA_W-1:0]  origin_z;
    logic [DATA_W-1:0]  cell_scale;
    logic [DEPTH_W-1:0] grid_depth;
  } cfg_t;

  // Binned point leaving the address stage
  typedef struct packed {
    logic [CIDX_W-1:0] idx;
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
    logic [CELL_W-1:0] cz;
    logic              any_color;
    logic              any_class;
    logic [DATA_W-1:0] total;
  } bin_t;

  // Finished result
  typedef struct packed {
    logic [IDX_W-1:0]     cell_index;
    logic [COORD_W-1:0]   cell_x;
    logic [COORD_W-1:0]   cell_y;
    logic [COORD_W-1:0]   cell_z;
    logic [OUT_CNT_W-1:0] cell_count;
    logic                 any_color;
    logic                 any_class;
    logic [DATA_W-1:0]    total_points;
  } result_t;

endpackage

[src/pvb_ram.sv]
// ----------------------------------------------------------------------------
// pvb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered (old data on collision).
// ----------------------------------------------------------------------------
module pvb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/pvb_bin.sv]
// ----------------------------------------------------------------------------
// pvb_bin: binning pipeline
// Origin subtract, scale multiply, floor/clamp and index linearization in
// three registered stages; keeps the sticky flags and the point total.
// ----------------------------------------------------------------------------
module pvb_bin (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_acc,
  input  logic [pvb_pkg::DATA_W-1:0]  pos_x,
  input  logic [pvb_pkg::DATA_W-1:0]  pos_y,
  input  logic [pvb_pkg::DATA_W-1:0]  pos_z,
  input  logic                      has_color,
  input  logic [pvb_pkg::CLASS_W-1:0] point_class,
  input  pvb_pkg::cfg_t             cfg,
  output logic                      s3_valid,
  output pvb_pkg::bin_t             s3
);

  localparam int PROD_W = 2 * pvb_pkg::DATA_W;
  localparam int FRAC_W = 16;
  localparam int FLR_W  = PROD_W - FRAC_W;

  // positive part of pos - org, zero when the point is at or below origin
  function automatic logic [pvb_pkg::DATA_W-1:0] pos_part(
    input logic [pvb_pkg::DATA_W-1:0] p,
    input logic [pvb_pkg::DATA_W-1:0] o
  );
    logic [pvb_pkg::DATA_W:0] d;
    d = {p[pvb_pkg::DATA_W-1], p} - {o[pvb_pkg::DATA_W-1], o};
    if (!d[pvb_pkg::DATA_W] && (|d[pvb_pkg::DATA_W-1:0])) begin
      return d[pvb_pkg::DATA_W-1:0];
    end
    return '0;
  endfunction

  // floor (drop fraction) and clamp to dim-1
  function automatic logic [pvb_pkg::CELL_W-1:0] clamp_cell(
    input logic [PROD_W-1:0]         prod,
    input logic [pvb_pkg::CELL_W-1:0] lim
  );
    logic [FLR_W-1:0] fl;
    fl = prod[PROD_W-1:FRAC_W];
    if (fl > FLR_W'(lim)) begin
      return lim;
    end
    return fl[pvb_pkg::CELL_W-1:0];
  endfunction

  // sticky flags and saturating total
  logic                      color_r, color_nxt;
  logic                      class_r, class_nxt;
  logic [pvb_pkg::DATA_W-1:0] total_r, total_nxt;

  always_comb begin
    color_nxt = color_r | (in_acc & has_color);
    class_nxt = class_r | (in_acc & (|point_class));
    total_nxt = (in_acc && !(&total_r)) ? total_r + 1'b1 : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= 1'b0;
      class_r <= 1'b0;
      total_r <= '0;
    end else begin
      color_r <= color_nxt;
      class_r <= class_nxt;
      total_r <= total_nxt;
    end
  end

  // stage valids
  logic v1_r, v2_r, v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: origin subtract
  logic [pvb_pkg::DATA_W-1:0] d1x_r, d1y_r, d1z_r;
  logic                      c1_r, k1_r;
  logic [pvb_pkg::DATA_W-1:0] t1_r;

  always_ff @(posedge clk) begin
    d1x_r <= pos_part(pos_x, cfg.origin_x);
    d1y_r <= pos_part(pos_y, cfg.origin_y);
    d1z_r <= pos_part(pos_z, cfg.origin_z);
    c1_r  <= color_nxt;
    k1_r  <= class_nxt;
    t1_r  <= total_nxt;
  end

  // stage 2: one 32x32 multiply per axis
  logic [PROD_W-1:0]         p2x_r, p2y_r, p2z_r;
  logic                      c2_r, k2_r;
  logic [pvb_pkg::DATA_W-1:0] t2_r;

  always_ff @(posedge clk) begin
    p2x_r <= PROD_W'(d1x_r) * PROD_W'(cfg.cell_scale);
    p2y_r <= PROD_W'(d1y_r) * PROD_W'(cfg.cell_scale);
    p2z_r <= PROD_W'(d1z_r) * PROD_W'(cfg.cell_scale);
    c2_r  <= c1_r;
    k2_r  <= k1_r;
    t2_r  <= t1_r;
  end

  // stage 3: clamp and linearize x-major
  logic [pvb_pkg::DEPTH_W-1:0] depth;
  logic [pvb_pkg::CELL_W-1:0]  lim;
  logic [pvb_pkg::CELL_W-1:0]  cx, cy, cz;
  logic [pvb_pkg::CIDX_W-1:0]  idx;

  always_comb begin
    depth = (cfg.grid_depth > pvb_pkg::DEPTH_W'(pvb_pkg::MAX_DEPTH))
          ? pvb_pkg::DEPTH_W'(pvb_pkg::MAX_DEPTH) : cfg.grid_depth;
    lim   = ~({pvb_pkg::CELL_W{1'b1}} << depth);
    cx    = clamp_cell(p2x_r, lim);
    cy    = clamp_cell(p2y_r, lim);
    cz    = clamp_cell(p2z_r, lim);
    idx   = (pvb_pkg::CIDX_W'(cx) << {depth, 1'b0})
          | (pvb_pkg::CIDX_W'(cy) << depth)
          | pvb_pkg::CIDX_W'(cz);
  end

  always_ff @(posedge clk) begin
    s3.idx       <= idx;
    s3.cx        <= cx;
    s3.cy        <= cy;
    s3.cz        <= cz;
    s3.any_color <= c2_r;
    s3.any_class <= k2_r;
    s3.total     <= t2_r;
  end

  assign s3_valid = v3_r;

endmodule

[src/pvb_hist.sv]
// ----------------------------------------------------------------------------
// pvb_hist: per-cell counter update
// Read-modify-write of the counter memory with one-entry write forwarding,
// plus the clearing pass after reset.
// ----------------------------------------------------------------------------
module pvb_hist (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s3_valid,
  input  pvb_pkg::bin_t      s3,
  output logic               clear_done,
  output logic               res_valid,
  output pvb_pkg::result_t   res
);

  localparam int CW = pvb_pkg::COUNT_BITS;

  // clearing pass, one entry per cycle
  logic                       clr_busy_r;
  logic [pvb_pkg::CIDX_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign clear_done = !clr_busy_r;

  // update stage
  logic               s4_valid_r;
  pvb_pkg::bin_t      s4_r;
  logic               fwd_hit_r;
  logic [CW-1:0]      fwd_data_r;
  logic [CW-1:0]      rdata;
  logic [CW-1:0]      base;
  logic [CW-1:0]      cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid;
      // the point now updating writes back at this edge, after s3 was read
      fwd_hit_r  <= s4_valid_r && s3_valid && (s4_r.idx == s3.idx);
    end
  end

  always_ff @(posedge clk) begin
    s4_r       <= s3;
    fwd_data_r <= cnt_nxt;
  end

  // saturating increment
  always_comb begin
    base    = fwd_hit_r ? fwd_data_r : rdata;
    cnt_nxt = (&base) ? base : base + 1'b1;
  end

  // counter memory
  logic                       ram_we;
  logic [pvb_pkg::CIDX_W-1:0] ram_waddr;
  logic [CW-1:0]              ram_wdata;

  always_comb begin
    ram_we    = clr_busy_r | s4_valid_r;
    ram_waddr = clr_busy_r ? clr_addr_r : s4_r.idx;
    ram_wdata = clr_busy_r ? '0 : cnt_nxt;
  end

  pvb_ram #(
    .WIDTH (CW),
    .DEPTH (pvb_pkg::NUM_CELLS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (s3.idx),
    .rdata (rdata)
  );

  // result
  always_comb begin
    res_valid        = s4_valid_r;
    res.cell_index   = pvb_pkg::IDX_W'(s4_r.idx);
    res.cell_x       = pvb_pkg::COORD_W'(s4_r.cx);
    res.cell_y       = pvb_pkg::COORD_W'(s4_r.cy);
    res.cell_z       = pvb_pkg::COORD_W'(s4_r.cz);
    res.cell_count   = pvb_pkg::OUT_CNT_W'(cnt_nxt);
    res.any_color    = s4_r.any_color;
    res.any_class    = s4_r.any_class;
    res.total_points = s4_r.total;
  end

endmodule

[src/pvb_ofifo.sv]
// ----------------------------------------------------------------------------
// pvb_ofifo: result FIFO
// Holds finished results until the output side takes them; room is
// guaranteed by the credit count at the top level.
// ----------------------------------------------------------------------------
module pvb_ofifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pvb_pkg::result_t push_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pvb_pkg::result_t out_data
);

  pvb_pkg::result_t               mem_r [pvb_pkg::FIFO_DEPTH];
  logic [pvb_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [pvb_pkg::FIFO_CNT_W-1:0] cnt_r;
  logic                           pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/point_voxel_binning_histogram_unit.sv]
// ----------------------------------------------------------------------------
// point_voxel_binning_histogram_unit: voxel grid binning with cell histogram
// Bins each 3D point into a clamped grid cell and returns that cell's
// saturating count, two sticky flags and the saturating point total.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   in_*     | slave     | one point: position, colour flag, class
//   out_*    | master    | one result per point: cell, count, flags, total
//   cfg_*    | write     | origin x/y/z, cell_scale, grid_depth
//
// One point per cycle sustained while in_tready is high; a result passes the 3
// binning stages (the first loaded at the transfer edge), the counter memory
// read, and the update into the output FIFO before it is offered.
// After reset a clearing pass zeroes the 4096-entry counter memory, one entry
// per cycle; in_tready stays low until the pass is done.
// At most 8 points are outstanding (output FIFO depth); in_tready drops when
// the output side stalls long enough to fill it.
// Back-to-back hits on one cell are served by write-data forwarding.
// ----------------------------------------------------------------------------
module point_voxel_binning_histogram_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], has_color[96], point_class[104:97]
  input  logic [pvb_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // cell_index[11:0], cell_x[15:12], cell_y[19:16], cell_z[23:20],
  // cell_count[55:24], any_color[56], any_class[57], total_points[89:58]
  output logic [pvb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [pvb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pvb_pkg::DATA_W-1:0]         cfg_wdata
);

  // configuration registers
  pvb_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x   <= '0;
      cfg_r.origin_y   <= '0;
      cfg_r.origin_z   <= '0;
      cfg_r.cell_scale <= pvb_pkg::SCALE_RESET;
      cfg_r.grid_depth <= pvb_pkg::DEPTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pvb_pkg::CFG_ORIGIN_X:   cfg_r.origin_x   <= cfg_wdata;
        pvb_pkg::CFG_ORIGIN_Y:   cfg_r.origin_y   <= cfg_wdata;
        pvb_pkg::CFG_ORIGIN_Z:   cfg_r.origin_z   <= cfg_wdata;
        pvb_pkg::CFG_CELL_SCALE: cfg_r.cell_scale <= cfg_wdata;
        pvb_pkg::CFG_GRID_DEPTH: cfg_r.grid_depth <= cfg_wdata[pvb_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // credit: points accepted and not yet delivered
  logic                           clear_done;
  logic                           in_acc, out_acc;
  logic [pvb_pkg::FIFO_CNT_W-1:0] pend_r, pend_nxt;

  assign in_tready = clear_done && (pend_r < pvb_pkg::FIFO_CNT_W'(pvb_pkg::FIFO_DEPTH));
  assign in_acc    = in_tvalid & in_tready;
  assign out_acc   = out_tvalid & out_tready;

  always_comb begin
    unique case ({in_acc, out_acc})
      2'b10:   pend_nxt = pend_r + 1'b1;
      2'b01:   pend_nxt = pend_r - 1'b1;
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // binning pipeline
  logic          s3_valid;
  pvb_pkg::bin_t s3;

  pvb_bin u_bin (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_acc      (in_acc),
    .pos_x       (in_tdata[31:0]),
    .pos_y       (in_tdata[63:32]),
    .pos_z       (in_tdata[95:64]),
    .has_color   (in_tdata[96]),
    .point_class (in_tdata[104:97]),
    .cfg         (cfg_r),
    .s3_valid    (s3_valid),
    .s3          (s3)
  );

  // counter update
  logic             res_valid;
  pvb_pkg::result_t res;

  pvb_hist u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .s3_valid   (s3_valid),
    .s3         (s3),
    .clear_done (clear_done),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result FIFO
  pvb_pkg::result_t head;

  pvb_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (head)
  );

  // output packing
  assign out_tdata = {6'b0, head.total_points, head.any_class, head.any_color,
                      head.cell_count, head.cell_z, head.cell_y, head.cell_x,
                      head.cell_index};

endmodule

[src/pvb_checker.sv]
// ----------------------------------------------------------------------------
// pvb_checker: port-level checks of the binning histogram unit
// Output handshake, reset behavior and result sanity; bound to the top level.
// ----------------------------------------------------------------------------
module pvb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pvb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // reset starts the clearing pass and empties the result path
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block not quiet after reset");

  // every result counts its own point in the cell and in the total
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[55:24] != 32'd0) && (out_tdata[89:58] != 32'd0))
    else $error("result with zero cell count or zero total");

endmodule

bind point_voxel_binning_histogram_unit pvb_checker u_pvb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[test/point_voxel_binning_histogram_unit_tb.sv]
// ----------------------------------------------------------------------------
// point_voxel_binning_histogram_unit_tb: self-checking bench for voxel binning
// Streams 3D points into the unit, predicts each result in step (clamped cell
// coordinates, linear index, per-cell hit count, sticky flags, point total),
// and compares every result transfer field by field. Covers the register
// extremes, random grids, output backpressure and sender pauses.
// ----------------------------------------------------------------------------
module point_voxel_binning_histogram_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Clock, reset and DUT ports
  logic                            clk = 1'b0;
  logic                            rst_n;
  logic [pvb_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [pvb_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic                            cfg_we;
  logic [pvb_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [pvb_pkg::DATA_W-1:0]      cfg_wdata;

  always #5 clk = ~clk;

  point_voxel_binning_histogram_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Predicted grid state: register copy, cell hit counters, flags, total
  pvb_pkg::cfg_t     grid_cfg;
  logic [31:0]       cell_hits [pvb_pkg::NUM_CELLS];
  logic              color_seen;
  logic              class_seen;
  logic [31:0]       point_total;
  pvb_pkg::result_t  pending_results [$];

  int                fail_cnt    = 0;
  int                tx_max_gap  = 15;   // sender idle cycles per point, upper bound
  int                rx_max_stall = 15;  // receiver stall cycles per result, upper bound
  int                sink_hold   = 0;    // one-shot long receiver hold-off, in cycles

  // Cell coordinate on one axis: floor((pos - org) * scale / 2^16), clamped
  function automatic logic [3:0] axis_cell(logic [31:0] pos, logic [31:0] org,
                                           logic [31:0] scale, int unsigned dim);
    longint      diff;
    logic [63:0] prod;
    logic [47:0] cell_fl;
    diff = longint'($signed(pos)) - longint'($signed(org));
    if (diff <= 0) return 4'd0;
    prod = diff;
    prod = prod * {32'd0, scale};
    cell_fl = prod[63:16];
    if (cell_fl > dim - 1) cell_fl = 48'(dim - 1);
    return cell_fl[3:0];
  endfunction

  // Bin one point and update the predicted histogram state
  function automatic pvb_pkg::result_t bin_point(logic [31:0] px, logic [31:0] py,
                                                 logic [31:0] pz, logic color,
                                                 logic [7:0] cls);
    pvb_pkg::result_t r;
    int unsigned      depth;
    int unsigned      dim;
    int unsigned      lin;
    depth = (grid_cfg.grid_depth > pvb_pkg::MAX_DEPTH) ? pvb_pkg::MAX_DEPTH
                                                       : grid_cfg.grid_depth;
    dim   = 1 << depth;
    r.cell_x = axis_cell(px, grid_cfg.origin_x, grid_cfg.cell_scale, dim);
    r.cell_y = axis_cell(py, grid_cfg.origin_y, grid_cfg.cell_scale, dim);
    r.cell_z = axis_cell(pz, grid_cfg.origin_z, grid_cfg.cell_scale, dim);
    lin = ((r.cell_x * dim + r.cell_y) * dim + r.cell_z) & (pvb_pkg::NUM_CELLS - 1);
    if (color) color_seen = 1'b1;
    if (cls != 8'd0) class_seen = 1'b1;
    if (cell_hits[lin] != 32'hFFFF_FFFF) cell_hits[lin] = cell_hits[lin] + 32'd1;
    if (point_total != 32'hFFFF_FFFF) point_total = point_total + 32'd1;
    r.cell_index   = lin[11:0];
    r.cell_count   = cell_hits[lin];
    r.any_color    = color_seen;
    r.any_class    = class_seen;
    r.total_points = point_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Register write; only called while nothing is in flight
  task automatic write_reg(pvb_pkg::cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    unique case (idx)
      pvb_pkg::CFG_ORIGIN_X:   grid_cfg.origin_x   = val;
      pvb_pkg::CFG_ORIGIN_Y:   grid_cfg.origin_y   = val;
      pvb_pkg::CFG_ORIGIN_Z:   grid_cfg.origin_z   = val;
      pvb_pkg::CFG_CELL_SCALE: grid_cfg.cell_scale = val;
      pvb_pkg::CFG_GRID_DEPTH: grid_cfg.grid_depth = val[pvb_pkg::DEPTH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] scale, logic [2:0] depth);
    write_reg(pvb_pkg::CFG_ORIGIN_X, ox);
    write_reg(pvb_pkg::CFG_ORIGIN_Y, oy);
    write_reg(pvb_pkg::CFG_ORIGIN_Z, oz);
    write_reg(pvb_pkg::CFG_CELL_SCALE, scale);
    write_reg(pvb_pkg::CFG_GRID_DEPTH, {29'd0, depth});
  endtask

  // Offer one point after a random gap; predict it on the accepting edge
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic color, logic [7:0] cls);
    int               gap;
    pvb_pkg::result_t pred;
    gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {7'd0, cls, color, pz, py, px};
    in_tvalid = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    pred = bin_point(px, py, pz, color, cls);
    pending_results = {pending_results, pred};
  endtask

  // Stop offering and wait until every predicted result has been seen
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Position near the grid on one axis, sometimes anywhere
  function automatic logic [31:0] pick_coord(logic [31:0] org, logic [31:0] scale,
                                             int unsigned dim);
    longint          span;
    longint          p;
    longint unsigned r;
    if ($urandom_range(0, 6) == 0) return $urandom();
    if (scale == 0) span = 64;
    else span = (longint'(dim) << 16) / longint'(scale) + 1;
    r = {$urandom(), $urandom()};
    p = longint'($signed(org)) + longint'(r % (span + span / 2 + 1)) - span / 4;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom();
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      3:       return pvb_pkg::SCALE_RESET;
      default: return $urandom_range(32'h100, 32'h4_0000);
    endcase
  endfunction

  // Result side: random stall per result, plus the one-shot long hold-off
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else begin
        stall = (rx_max_stall == 0) ? 0 : $urandom_range(0, rx_max_stall);
      end
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  // Result checker: each transfer against the oldest prediction
  always @(posedge clk) begin
    pvb_pkg::result_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_tdata);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("cell_index",   32'(want.cell_index),   32'(out_tdata[11:0]));
        check_field("cell_x",       32'(want.cell_x),       32'(out_tdata[15:12]));
        check_field("cell_y",       32'(want.cell_y),       32'(out_tdata[19:16]));
        check_field("cell_z",       32'(want.cell_z),       32'(out_tdata[23:20]));
        check_field("cell_count",   want.cell_count,        out_tdata[55:24]);
        check_field("any_color",    32'(want.any_color),    32'(out_tdata[56]));
        check_field("any_class",    32'(want.any_class),    32'(out_tdata[57]));
        check_field("total_points", want.total_points,      out_tdata[89:58]);
      end
    end
  end

  // Reset register values, near-origin points, clamping, flags rising
  task automatic test_default_grid();
    send_point(32'd0, 32'd0, 32'd0, 1'b0, 8'd0);
    send_point(32'd0, 32'd0, 32'd0, 1'b0, 8'd0);   // same cell again
    send_point(32'd1, 32'd2, 32'd3, 1'b0, 8'd0);
    send_point(32'd15, 32'd15, 32'd15, 1'b0, 8'd0);
    send_point(32'd16, 32'd1000, 32'h7FFF_FFFF, 1'b0, 8'd1);
    send_point(32'hFFFF_FFFF, 32'h8000_0000, -32'sd7, 1'b1, 8'd0); // below origin
    send_point(32'd5, 32'd9, 32'd12, 1'b1, 8'hFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 8'h80);
    wait_idle();
  endtask

  // Extreme origins, scale and depth; fractional scale floors exactly
  task automatic test_register_extremes();
    write_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 3'd0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 8'd0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 8'd0);
    wait_idle();
    write_reg(pvb_pkg::CFG_GRID_DEPTH, 32'd7);         // saturates to the largest grid
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 1'b0, 8'd0);
    wait_idle();
    write_reg(pvb_pkg::CFG_CELL_SCALE, 32'd0);         // every point lands in cell 0
    send_point(32'h7FFF_FFFF, 32'h1234_5678, 32'h0000_0100, 1'b1, 8'd3);
    wait_idle();
    write_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, pvb_pkg::SCALE_RESET, 3'd2);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 8'd0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 8'd0);
    wait_idle();
    write_grid(32'd0, 32'd0, 32'd0, 32'h0000_8000, 3'd4);
    send_point(32'd31, 32'd3, 32'd30, 1'b0, 8'd0);
    send_point(32'd1, 32'd2, 32'd33, 1'b0, 8'd0);
    wait_idle();
    write_reg(pvb_pkg::CFG_GRID_DEPTH, 32'd1);
    send_point(32'd2, 32'd1, 32'd5, 1'b1, 8'd0);
    wait_idle();
  endtask

  // Long receiver hold-off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    int unsigned dim;
    write_grid(32'd0, 32'd0, 32'd0, 32'h0000_4000, 3'd3);
    dim          = 8;
    tx_max_gap   = 0;
    rx_max_stall = 0;
    sink_hold    = 400;
    repeat (40)
      send_point(pick_coord(32'd0, 32'h4000, dim), pick_coord(32'd0, 32'h4000, dim),
                 pick_coord(32'd0, 32'h4000, dim), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)));
    wait_idle();
    tx_max_gap   = 15;
    rx_max_stall = 15;
  endtask

  // Sender stops until the pipeline drains, then resumes
  task automatic test_sender_pause();
    repeat (2) begin
      repeat (16)
        send_point($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40),
                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      wait_idle();
    end
  endtask

  // Random grids with points aimed at and around each grid
  task automatic test_random_binning(int phases, int per_phase);
    int unsigned dim;
    logic [31:0] px, py, pz;
    logic        color;
    logic [7:0]  cls;
    for (int ph = 0; ph < phases; ph++) begin
      write_grid(pick_origin(), pick_origin(), pick_origin(), pick_scale(),
                 (ph == 0) ? 3'd0 : (ph == 1) ? 3'd4 : 3'($urandom_range(0, 7)));
      dim = 1 << ((grid_cfg.grid_depth > pvb_pkg::MAX_DEPTH) ? pvb_pkg::MAX_DEPTH
                                                             : grid_cfg.grid_depth);
      case ($urandom_range(0, 3))
        0:       begin tx_max_gap = 0;  rx_max_stall = 0;  end
        1:       begin tx_max_gap = 15; rx_max_stall = 0;  end
        2:       begin tx_max_gap = 0;  rx_max_stall = 15; end
        default: begin tx_max_gap = 15; rx_max_stall = 15; end
      endcase
      px = grid_cfg.origin_x;
      py = grid_cfg.origin_y;
      pz = grid_cfg.origin_z;
      repeat (per_phase) begin
        // mostly fresh points; some repeat the last one to hit a hot cell
        if ($urandom_range(0, 4) != 0) begin
          px = pick_coord(grid_cfg.origin_x, grid_cfg.cell_scale, dim);
          py = pick_coord(grid_cfg.origin_y, grid_cfg.cell_scale, dim);
          pz = pick_coord(grid_cfg.origin_z, grid_cfg.cell_scale, dim);
        end
        color = 1'($urandom_range(0, 1));
        cls   = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        send_point(px, py, pz, color, cls);
      end
      wait_idle();
    end
    tx_max_gap   = 15;
    rx_max_stall = 15;
  endtask

  // Main sequence
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = pvb_pkg::CFG_ORIGIN_X;
    cfg_wdata = '0;
    grid_cfg  = '{origin_x: '0, origin_y: '0, origin_z: '0,
                  cell_scale: pvb_pkg::SCALE_RESET, grid_depth: pvb_pkg::DEPTH_RESET};
    foreach (cell_hits[i]) cell_hits[i] = '0;
    color_seen  = 1'b0;
    class_seen  = 1'b0;
    point_total = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // counter memory clearing pass
    while (in_tready !== 1'b1) @(posedge clk);

    test_default_grid();
    test_register_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_binning(8, 205);

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
src/pvb_pkg.sv
src/pvb_ram.sv
src/pvb_bin.sv
src/pvb_hist.sv
src/pvb_ofifo.sv
src/point_voxel_binning_histogram_unit.sv
src/pvb_checker.sv
test/point_voxel_binning_histogram_unit_tb.sv
